// ===== rtl/ptcs_pkg.sv =====
// Package: shared types and codes for the polynomial term store.
`default_nettype none
package ptcs_pkg;

    localparam int MAX_TERMS = 64;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int COEF_W    = 32;
    localparam int EXP_W     = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_TERM   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_DROP   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        logic                     cmd;
        logic signed [COEF_W-1:0] term_coef;
        logic signed [EXP_W-1:0]  term_exp;
    } t_item;

    typedef struct packed {
        logic signed [COEF_W-1:0] out_coef;
        logic signed [EXP_W-1:0]  out_exp;
        t_status                  status;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic signed [EXP_W-1:0]  exp;
    } t_entry;

endpackage
`default_nettype wire

// ===== rtl/poly_term_combine_sort.sv =====
// Top level: sparse polynomial term store with combine-on-insert and sorted flush.
// Insert: one memory read per stored entry until an exponent matches, then one result beat.
// Flush: count passes (max search over the term memory),
// one result beat per pass; empty flush answers on the next cycle, busy stays low.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-low reset empties the store; memory contents need no clearing.
`default_nettype none
module poly_term_combine_sort import ptcs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_item   i_item,
    output logic         busy,
    output logic         o_strobe,
    output t_result      o_result
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_INS   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    // term memory, one read and one write port, registered read
    t_entry mem [MAX_TERMS];
    t_entry rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             w_en;
    logic [IDX_W-1:0] w_addr;
    t_entry           w_data;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        rd_data <= mem[rd_addr];
    end

    // control and datapath registers
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic             r_pend, n_pend;
    t_item            r_item, n_item;
    logic             r_found, n_found;
    t_entry           r_best, n_best;
    logic             r_bnd_vld, n_bnd_vld;
    logic signed [EXP_W-1:0] r_bound, n_bound;
    logic [CNT_W-1:0] r_emit, n_emit;
    logic             r_strobe, n_strobe;
    t_result          r_out, n_out;

    logic hit;
    logic cand;
    logic signed [COEF_W-1:0] sum;

    assign rd_addr = r_idx[IDX_W-1:0];
    assign hit     = r_pend && (rd_data.exp == r_item.term_exp);
    assign sum     = rd_data.coef + r_item.term_coef;
    // flush candidate: below the last emitted exponent and above the best so far
    assign cand    = r_pend && (!r_bnd_vld || (rd_data.exp < r_bound))
                     && (!r_found || (rd_data.exp > r_best.exp));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pend    = 1'b0;
        n_item    = r_item;
        n_found   = r_found;
        n_best    = r_best;
        n_bnd_vld = r_bnd_vld;
        n_bound   = r_bound;
        n_emit    = r_emit;
        n_strobe  = 1'b0;
        n_out     = r_out;
        w_en      = 1'b0;
        w_addr    = r_count[IDX_W-1:0];
        w_data    = '{coef: r_item.term_coef, exp: r_item.term_exp};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item    = i_item;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_bnd_vld = 1'b0;
                    n_emit    = '0;
                    if (i_item.cmd == CMD_INSERT) begin
                        n_state = S_INS;
                    end else if (r_count == '0) begin
                        // empty store: answer at once
                        n_strobe = 1'b1;
                        n_out    = '{out_coef: '0, out_exp: '0,
                                     status: ST_EMPTY, last: 1'b1};
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end

            // insert: compare each read beat, combine on hit; append at the end, or drop when the store is full
            S_INS: begin
                if (hit) begin
                    w_en     = 1'b1;
                    w_addr   = r_pidx;
                    w_data   = '{coef: sum, exp: r_item.term_exp};
                    n_strobe = 1'b1;
                    n_out    = '{out_coef: sum, out_exp: r_item.term_exp,
                                 status: ST_ACCEPT, last: 1'b1};
                    n_state  = S_IDLE;
                end else if (r_idx != r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + 1'b1;
                end else if (r_count == CNT_W'(MAX_TERMS)) begin
                    n_strobe = 1'b1;
                    n_out    = '{out_coef: '0, out_exp: '0,
                                 status: ST_DROP, last: 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    w_en     = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_strobe = 1'b1;
                    n_out    = '{out_coef: r_item.term_coef, out_exp: r_item.term_exp,
                                 status: ST_ACCEPT, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end

            // flush: one max-search pass per emitted term
            S_FLUSH: begin
                if (cand) begin
                    n_found = 1'b1;
                    n_best  = rd_data;
                end
                if (r_idx != r_count) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_strobe  = 1'b1;
                    n_out     = '{out_coef: r_best.coef, out_exp: r_best.exp,
                                  status: ST_TERM,
                                  last: (r_emit == r_count - 1'b1)};
                    n_bound   = r_best.exp;
                    n_bnd_vld = 1'b1;
                    n_found   = 1'b0;
                    n_idx     = '0;
                    n_emit    = r_emit + 1'b1;
                    if (r_emit == r_count - 1'b1) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_item    <= n_item;
        r_found   <= n_found;
        r_best    <= n_best;
        r_bnd_vld <= n_bnd_vld;
        r_bound   <= n_bound;
        r_emit    <= n_emit;
        r_out     <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ===== rtl/ptcs_checker.sv =====
// Checker: port-level properties of the term store, bound to the top level.
`default_nettype none
module ptcs_assert import ptcs_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire t_item   i_item,
    input wire logic    busy,
    input wire logic    o_strobe,
    input wire t_result o_result
);

    // an accepted beat occupies the block or is answered at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted beat neither raised busy nor answered");

    // results come only out of a busy period or right after an accepted beat
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy || start))
        else $error("result beat without preceding busy cycle or accepted beat");

    // single-result answers close their item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_TERM)) |-> o_result.last)
        else $error("single-result answer without last");

    // dropped and empty answers carry zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ((o_result.status == ST_DROP) || (o_result.status == ST_EMPTY)))
        |-> ((o_result.out_coef == '0) && (o_result.out_exp == '0)))
        else $error("drop or empty answer with nonzero payload");

    // block goes idle only after the last result beat
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("block idle before last result beat");

endmodule

bind poly_term_combine_sort ptcs_assert u_ptcs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
`default_nettype wire
